// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the sha-256 byte stream
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // block job handed from front to back
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } sha_job_t;

  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// collects bytes into 64-byte blocks, adds padding and length, emits jobs
// ----------------------------------------------------------------------------
module sha_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha_pkg::sha_in_t  in_data_i,
  output logic              job_valid_o,
  input  logic              job_stall_i,
  output sha_pkg::sha_job_t job_o
);
  import sha_pkg::*;

  typedef enum logic [1:0] {
    StFill,
    StPad2,
    StLen
  } state_e;

  state_e       state_q;
  logic [511:0] buf_q;
  logic [60:0]  cnt_q;
  logic         job_valid_q;
  sha_job_t     job_q;
  logic [511:0] cur_blk;
  logic [511:0] len_blk;
  logic [5:0]   pos;
  logic [63:0]  bits;
  logic         accept;
  logic         can_emit;
  logic         job_load;

  assign pos      = cnt_q[5:0];
  assign bits     = {cnt_q, 3'b000};
  assign can_emit = !job_valid_q || !job_stall_i;
  assign in_stall_o = (state_q != StFill) || !can_emit;
  assign accept   = in_valid_i && !in_stall_o;
  assign job_valid_o = job_valid_q;
  assign job_o    = job_q;
  assign job_load = (state_q == StFill)
                  ? (accept && (in_data_i.end_of_message
                                || (in_data_i.carries_byte && pos == 6'd63)))
                  : can_emit;

  function automatic logic [7:0] bits_byte(input int j, input logic [60:0] c);
    logic [63:0] bb;
    bb = {c, 3'b000};
    return bb[63 - 8*j -: 8];
  endfunction

  // block as it stands in the buffer plus this transaction's byte, padding and length
  always_comb begin
    logic [5:0] p;
    logic       has_b;
    has_b = in_data_i.carries_byte;
    p     = pos + {5'd0, has_b};
    for (int i = 0; i < 64; i++) begin
      logic [7:0] b;
      b = buf_q[511 - 8*i -: 8];
      if (has_b && i == int'(pos)) b = in_data_i.data_byte;
      if (in_data_i.end_of_message) begin
        if (!(has_b && pos == 6'd63)) begin
          if (i == int'(p)) b = PadByte;
          else if (i > int'(p)) b = 8'h00;
        end
        if (i >= 56 && !(has_b && pos == 6'd63) && p < 6'd56)
          b = bits_byte(i - 56, cnt_q + {60'd0, has_b});
      end
      cur_blk[511 - 8*i -: 8] = b;
    end
  end

  always_comb begin
    len_blk = '0;
    if (state_q == StPad2 && pos == 6'd0) len_blk[511] = 1'b1;
    len_blk[63:0] = bits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StFill;
      cnt_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (job_load) job_valid_q <= 1'b1;
      else if (job_valid_q && !job_stall_i) job_valid_q <= 1'b0;
      unique case (state_q)
        StFill: begin
          if (accept) begin
            logic [60:0] nc;
            logic [5:0]  p;
            nc = cnt_q + {60'd0, in_data_i.carries_byte};
            p  = nc[5:0];
            if (in_data_i.carries_byte) buf_q[{~pos, 3'b000} +: 8] <= in_data_i.data_byte;
            if (in_data_i.carries_byte && pos == 6'd63) begin
              cnt_q           <= nc;
              job_q.block     <= cur_blk;
              job_q.final_blk <= 1'b0;
              if (in_data_i.end_of_message) state_q <= StPad2;
            end else if (in_data_i.end_of_message) begin
              job_q.block <= cur_blk;
              if (p < 6'd56) begin
                job_q.final_blk <= 1'b1;
                cnt_q <= '0;
              end else begin
                job_q.final_blk <= 1'b0;
                cnt_q <= nc;
                state_q <= StLen;
              end
            end else begin
              cnt_q <= nc;
            end
          end
        end
        StPad2, StLen: begin
          if (can_emit) begin
            job_q.block     <= len_blk;
            job_q.final_blk <= 1'b1;
            cnt_q           <= '0;
            state_q         <= StFill;
          end
        end
        default: state_q <= StFill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sha_queue.sv =====
// ----------------------------------------------------------------------------
// sha_queue
// short block job queue between front and back
// ----------------------------------------------------------------------------
module sha_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_stall_o,
  input  sha_pkg::sha_job_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_stall_i,
  output sha_pkg::sha_job_t rd_data_o
);
  import sha_pkg::*;

  sha_job_t mem_q [QueueDepth];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  logic     wr, rd;

  assign wr_stall_o = (cnt_q == 2'(QueueDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/sha_back.sv =====
// ----------------------------------------------------------------------------
// sha_back
// one compression round per cycle, chain update and digest word output
// ----------------------------------------------------------------------------
module sha_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_stall_o,
  input  sha_pkg::sha_job_t job_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StRound,
    StAdd,
    StEmit
  } state_e;

  state_e      state_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic [2:0]  widx_q;
  logic        fin_q;
  logic        out_valid_q;
  sha_out_t    out_q;
  logic [31:0] wnew, w, t1, t2, s0, s1;

  assign job_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    s0   = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    w    = (rnd_q < 6'd16) ? w_q[0] : wnew;
    t1 = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w;
    t2 = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      rnd_q       <= '0;
      widx_q      <= '0;
      fin_q       <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[255 - 32*i -: 32];
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            for (int i = 0; i < 16; i++) w_q[i] <= job_i.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            fin_q   <= job_i.final_blk;
            rnd_q   <= '0;
            state_q <= StRound;
          end
        end
        StRound: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w;
          for (int i = 1; i < 8; i++) if (i != 4) v_q[i] <= v_q[i-1];
          v_q[4] <= v_q[3] + t1;
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          widx_q  <= '0;
          state_q <= fin_q ? StEmit : StIdle;
        end
        StEmit: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q       <= 1'b1;
            out_q.digest_word <= h_q[widx_q];
            out_q.word_index  <= widx_q;
            out_q.last_word   <= (widx_q == 3'd7);
            widx_q            <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitH[255 - 32*i -: 32];
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      if (out_valid_q && !out_stall_i && !(state_q == StEmit)) out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/sha256_digest_stream.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_stream
// sha-256 over a byte stream, eight digest words per message
// ----------------------------------------------------------------------------
// usage: one message byte per input transaction; end_of_message closes the
// message (after its byte, if carries_byte is set). eight output
// transactions follow, word_index 0 to 7, last_word on the eighth.
// the front takes one byte per cycle while a block is filling, unless the
// queue backs up; a full block goes into a two-entry job queue and the back
// runs it one round per cycle through a single round unit, taking a new
// block only once done with the last, so the round unit sets the sustained rate.
// a message end adds one or two blocks, then eight digest transactions,
// one per cycle unless the receiver stalls. a stall holds the result
// register and backs the queue up, then stalls the input side.
// reset returns the chain to its initial value and empties the queue.
// ----------------------------------------------------------------------------
module sha256_digest_stream (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha_pkg::sha_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha_pkg::sha_out_t out_data_o
);
  import sha_pkg::*;

  logic     fj_valid, fj_stall, bj_valid, bj_stall;
  sha_job_t fj, bj;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(fj_valid), .job_stall_i(fj_stall), .job_o(fj)
  );

  sha_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_stall_o(fj_stall), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_stall_i(bj_stall), .rd_data_o(bj)
  );

  sha_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_stall_o(bj_stall), .job_i(bj),
    .out_valid_o, .out_stall_i, .out_data_o
  );

`ifndef NO_ASSERTIONS
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)))
    else $error("last_word mismatch");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_word) ##1 out_valid_o
      |-> out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
    else $error("digest word order");
`endif

endmodule

// ===== test/tb_sha256_digest_stream.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_digest_stream
// checks the sha-256 byte stream block against a behavioral digest computed
// in the testbench; directed messages (empty, padding edges, byte with end)
// are followed by random messages with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb_sha256_digest_stream;
  import sha_pkg::*;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  class digest_scoreboard;
    logic [31:0] hash [8];
    logic [7:0]  blk [64];
    logic [60:0] nbytes;
    sha_out_t    pending [$];
    int          errors;
    int          messages;

    function new();
      hash = H0;
      nbytes = '0;
      errors = 0;
      messages = 0;
    endfunction

    function logic [31:0] rr(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
      v = hash;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + w[r];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash[i] += v[i];
    endfunction

    function void note_input(sha_in_t t);
      int p;
      logic [63:0] bits;
      sha_out_t o;
      if (t.carries_byte) begin
        p = int'(nbytes[5:0]);
        blk[p] = t.data_byte;
        nbytes++;
        if (p == 63) compress();
      end
      if (!t.end_of_message) return;
      p = int'(nbytes[5:0]);
      blk[p++] = PadByte;
      if (p > 56) begin
        while (p < 64) blk[p++] = 8'h00;
        compress();
        p = 0;
      end
      while (p < 56) blk[p++] = 8'h00;
      bits = {nbytes, 3'b000};
      for (int i = 0; i < 8; i++) blk[56+i] = bits[8*(7-i) +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash[i];
        o.word_index = 3'(i);
        o.last_word = (i == 7);
        pending.insert(pending.size(), o);
      end
      hash = H0;
      nbytes = '0;
      messages++;
    endfunction

    function void check_result(sha_out_t a);
      sha_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h idx %0d", a.digest_word,
                                   a.word_index);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d", e.digest_word, e.word_index,
                   e.last_word, a.digest_word, a.word_index, a.last_word);
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  sha_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  sha_out_t out_data_o;

  digest_scoreboard sb = new();
  int  idle_cycles = 0;
  int  items_sent = 0;
  bit  timed_out = 0;
  bit  no_gaps = 0;
  localparam int WatchdogLimit = 5000;

  always #5 clk_i = ~clk_i;

  sha256_digest_stream i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // receiver: random stall lengths per transaction
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i)
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("Verification failed");
      $finish;
    end

  task automatic send_item(logic [7:0] b, logic cb, logic eom);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, carries_byte: cb, end_of_message: eom};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_message(int len, bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1));
    if (!end_with_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    int len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty message, idle item, extreme bytes, padding edges
    send_item(8'hff, 1'b0, 1'b0);
    send_message(0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_message(3, 1'b1);
    drain();
    no_gaps = 1;
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    no_gaps = 0;
    send_message(64, 1'b1);
    drain();
    // random messages, mostly short, occasional idle items
    while (items_sent < 270) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      if ($urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if ($urandom_range(0, 3) == 0) no_gaps = 1;
      send_message(len, 1'($urandom_range(0, 1)));
      no_gaps = 0;
    end
    drain();
    $display("sent %0d input items, %0d messages incl. empty and padding edges",
             items_sent, sb.messages);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
